/* src/brt_pkg.sv */
package brt_pkg;

   localparam int ENTRIES  = 32;
   localparam int ENTRY_AW = 5;
   localparam int SLOTS    = 16;
   localparam int SLOT_AW  = 4;
   localparam int CSR_AW   = 3;

   localparam logic [ENTRY_AW-1:0] LAST_ENTRY = ENTRY_AW'(ENTRIES - 1);
   localparam logic [4:0] NOT_RES   = 5'd31;
   localparam logic [4:0] SIU_RESET = 5'd16;
   localparam logic [4:0] SIU_MAX   = 5'(SLOTS);
   localparam logic [CSR_AW-1:0] ADDR_SLOTS_IN_USE = '0;

   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_GET      = 3'd1;
   localparam logic [2:0] OP_FIND     = 3'd2;
   localparam logic [2:0] OP_SELECT   = 3'd3;
   localparam logic [2:0] OP_COMMIT   = 3'd4;
   localparam logic [2:0] OP_FREE     = 3'd5;

   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_INVALID  = 4'd1;
   localparam logic [3:0] ST_OVERFLOW = 4'd2;
   localparam logic [3:0] ST_QUOTA    = 4'd3;
   localparam logic [3:0] ST_EXISTS   = 4'd4;
   localparam logic [3:0] ST_NOTFOUND = 4'd5;
   localparam logic [3:0] ST_INCONS   = 4'd6;
   localparam logic [3:0] ST_NOSPACE  = 4'd7;
   localparam logic [3:0] ST_ALREADY  = 4'd8;
   localparam logic [3:0] ST_BUSY     = 4'd9;

   localparam logic [1:0] MODE_LOOKUP  = 2'd0;
   localparam logic [1:0] MODE_FIND    = 2'd1;
   localparam logic [1:0] MODE_OVERLAP = 2'd2;

   localparam logic [1:0] STEP_MAIN   = 2'd0;
   localparam logic [1:0] STEP_OLD    = 2'd1;
   localparam logic [1:0] STEP_VICTIM = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [63:0] region_base;
      logic [63:0] region_size;
      logic [1:0]  region_perms;
      logic [1:0]  lifetime_kind;
      logic [7:0]  entry_flags;
      logic [63:0] handle_in;
      logic [63:0] lookup_address;
      logic [1:0]  access_wanted;
      logic [3:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] handle_out;
      logic [3:0]  slot_out;
      logic [63:0] victim_handle;
      logic [63:0] entry_low;
      logic [63:0] entry_high;
      logic [1:0]  entry_perms;
      logic        entry_lifetime;
      logic        entry_pinned;
      logic        slot_clear_request;
   } rsp_type;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic [3:0]  attr;
      logic [63:0] handle;
   } entry_type;

endpackage

/* src/brt_req_if.sv */
interface brt_req_if import brt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/brt_rsp_if.sv */
interface brt_rsp_if import brt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* src/brt_store.sv */
module brt_store import brt_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ENTRY_AW-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic [ENTRY_AW-1:0] rd_addr,
   output entry_type           rd_data
);
   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/bounds_region_table_slot_manager.sv */
// Region table and bound-slot manager. Each request transaction carries one
// opcode (register, get, find, select slot, commit, free) and yields exactly
// one response transaction. The block takes one request at a time: the
// region table sits in a memory with one write port and one registered read
// port, and one shared compare unit walks it entry by entry, reading each
// entry in S_RD and checking it in S_CHK. Select may walk the slot ring twice
// and look up each occupant on the second pass. A finished response waits in
// an output register, so the next request is accepted while it is pending.
// The user must write slots_in_use through the csr_ port only while the block
// is idle; the block itself does not enforce this.
module bounds_region_table_slot_manager import brt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   brt_req_if.sink           req_chan,
   brt_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_RD     = 9'b000000010,
      S_CHK    = 9'b000000100,
      S_LKDONE = 9'b000001000,
      S_MOD    = 9'b000010000,
      S_SLOT   = 9'b000100000,
      S_WRITE  = 9'b001000000,
      S_COMMIT = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [63:0]         key_ff, key_in;
   logic [63:0]         hi_ff, hi_in;
   logic [ENTRY_AW-1:0] idx_ff, idx_in;
   logic [ENTRY_AW-1:0] e_ff, e_in;
   logic [ENTRY_AW-1:0] fr_ff, fr_in;
   logic                fr_found_ff, fr_found_in;
   logic [1:0]          mode_ff, mode_in;
   logic [1:0]          step_ff, step_in;
   logic                hit_ff, hit_in;
   entry_type           ent_ff, ent_in;
   logic [63:0]         last_ff, last_in;
   logic [5:0]          active_ff, active_in;
   logic [SLOT_AW-1:0]  vp_ff, vp_in;
   logic [4:0]          c_ff, c_in;
   logic [4:0]          cstart_ff, cstart_in;
   logic [SLOT_AW-1:0]  cnt_ff, cnt_in;
   logic                pass2_ff, pass2_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [4:0]          siu_ff, siu_in;
   logic                valid_ff [ENTRIES];
   logic                valid_in [ENTRIES];
   logic [4:0]          resid_ff [ENTRIES];
   logic [4:0]          resid_in [ENTRIES];
   logic [63:0]         owner_ff [SLOTS];
   logic [63:0]         owner_in [SLOTS];

   logic                wr_en;
   entry_type           wr_data;
   entry_type           rd_ent;
   logic                table_ok;
   logic [64:0]         sum;
   logic                hit;
   logic                cur_valid;
   logic [4:0]          r;
   logic                r_none;
   logic                r_bad;
   logic [4:0]          c_next;
   logic                cnt_last;
   req_type             p;

   brt_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fr_ff),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_ent)
   );

   assign p          = req_chan.payload;
   assign table_ok   = (siu_ff != 5'd0) && (siu_ff <= SIU_MAX);
   assign sum        = {1'b0, p.region_base} + {1'b0, p.region_size};
   assign cur_valid  = valid_ff[idx_ff];
   assign r          = resid_ff[idx_ff];
   assign r_none     = (r == NOT_RES);
   assign r_bad      = !r_none && ((r >= siu_ff) || (owner_ff[r[SLOT_AW-1:0]] != key_ff));
   assign c_next     = (c_ff + 5'd1 == siu_ff) ? 5'd0 : c_ff + 5'd1;
   assign cnt_last   = ({1'b0, cnt_ff} == siu_ff - 5'd1);
   assign wr_data    = '{low: req_ff.region_base, high: hi_ff,
                         attr: {req_ff.entry_flags[0], req_ff.lifetime_kind[0],
                                req_ff.region_perms},
                         handle: last_ff + 64'd1};

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr == ADDR_SLOTS_IN_USE) ? {27'd0, siu_ff} : 32'd0;

   always_comb begin
      unique case (mode_ff)
         MODE_LOOKUP:  hit = cur_valid && (rd_ent.handle == key_ff);
         MODE_FIND:    hit = cur_valid && (req_ff.lookup_address >= rd_ent.low) &&
                             (req_ff.lookup_address < rd_ent.high) &&
                             ((rd_ent.attr[1:0] & req_ff.access_wanted) ==
                              req_ff.access_wanted);
         MODE_OVERLAP: hit = cur_valid && (req_ff.region_base < rd_ent.high) &&
                             (rd_ent.low < hi_ff);
         default:      hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      key_in       = key_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      e_in         = e_ff;
      fr_in        = fr_ff;
      fr_found_in  = fr_found_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      ent_in       = ent_ff;
      last_in      = last_ff;
      active_in    = active_ff;
      vp_in        = vp_ff;
      c_in         = c_ff;
      cstart_in    = cstart_ff;
      cnt_in       = cnt_ff;
      pass2_in     = pass2_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      siu_in       = siu_ff;
      valid_in     = valid_ff;
      resid_in     = resid_ff;
      owner_in     = owner_ff;
      wr_en        = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == ADDR_SLOTS_IN_USE)) begin
         siu_in = csr_pwdata[4:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_in      = p;
               key_in      = p.handle_in;
               hi_in       = sum[63:0];
               res_in      = '0;
               idx_in      = '0;
               fr_found_in = 1'b0;
               step_in     = STEP_MAIN;
               mode_in     = MODE_LOOKUP;
               state_in    = S_OUT;
               if (!table_ok || p.opcode > OP_FREE) begin
                  res_in.status = ST_INVALID;
               end else begin
                  case (p.opcode)
                     OP_REGISTER: begin
                        if (p.region_size == 64'd0) begin
                           res_in.status = ST_INVALID;
                        end else if (sum[64]) begin
                           res_in.status = ST_OVERFLOW;
                        end else if (p.region_perms == 2'd0 || p.lifetime_kind > 2'd1 ||
                                     p.entry_flags[7:1] != 7'd0) begin
                           res_in.status = ST_INVALID;
                        end else if (active_ff >= 6'(ENTRIES)) begin
                           res_in.status = ST_QUOTA;
                        end else begin
                           mode_in  = MODE_OVERLAP;
                           state_in = S_RD;
                        end
                     end
                     OP_FIND: begin
                        if (p.access_wanted == 2'd0) begin
                           res_in.status = ST_INVALID;
                        end else begin
                           mode_in  = MODE_FIND;
                           state_in = S_RD;
                        end
                     end
                     OP_COMMIT: begin
                        if ({1'b0, p.slot_in} >= siu_ff || p.handle_in == 64'd0) begin
                           res_in.status = ST_INVALID;
                        end else begin
                           state_in = S_RD;
                        end
                     end
                     default: begin
                        if (p.handle_in == 64'd0) begin
                           res_in.status = ST_INVALID;
                        end else begin
                           state_in = S_RD;
                        end
                     end
                  endcase
               end
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (mode_ff == MODE_OVERLAP && !cur_valid && !fr_found_ff) begin
               fr_in       = idx_ff;
               fr_found_in = 1'b1;
            end
            if (hit) begin
               case (mode_ff)
                  MODE_LOOKUP: begin
                     hit_in   = 1'b1;
                     ent_in   = rd_ent;
                     state_in = S_LKDONE;
                  end
                  MODE_FIND: begin
                     res_in.handle_out = rd_ent.handle;
                     state_in          = S_OUT;
                  end
                  default: begin
                     res_in.status = ST_EXISTS;
                     state_in      = S_OUT;
                  end
               endcase
            end else if (idx_ff == LAST_ENTRY) begin
               case (mode_ff)
                  MODE_LOOKUP: begin
                     hit_in   = 1'b0;
                     state_in = S_LKDONE;
                  end
                  MODE_FIND: begin
                     res_in.status = ST_NOTFOUND;
                     state_in      = S_OUT;
                  end
                  default: begin
                     if (!fr_found_ff && cur_valid) begin
                        res_in.status = ST_QUOTA;
                        state_in      = S_OUT;
                     end else if (last_ff == '1) begin
                        res_in.status = ST_OVERFLOW;
                        state_in      = S_OUT;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
               endcase
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_WRITE: begin
            wr_en             = 1'b1;
            valid_in[fr_ff]   = 1'b1;
            resid_in[fr_ff]   = NOT_RES;
            active_in         = active_ff + 6'd1;
            last_in           = last_ff + 64'd1;
            res_in.handle_out = last_ff + 64'd1;
            state_in          = S_OUT;
         end
         S_LKDONE: begin
            state_in = S_OUT;
            case (step_ff)
               STEP_MAIN: begin
                  e_in = idx_ff;
                  if (!hit_ff) begin
                     res_in.status = ST_NOTFOUND;
                  end else begin
                     case (req_ff.opcode)
                        OP_GET: begin
                           res_in.entry_low      = ent_ff.low;
                           res_in.entry_high     = ent_ff.high;
                           res_in.entry_perms    = ent_ff.attr[1:0];
                           res_in.entry_lifetime = ent_ff.attr[2];
                           res_in.entry_pinned   = ent_ff.attr[3];
                        end
                        OP_SELECT: begin
                           if (r_bad) begin
                              res_in.status = ST_INCONS;
                           end else if (!r_none) begin
                              res_in.slot_out = r[SLOT_AW-1:0];
                           end else begin
                              c_in     = {1'b0, vp_ff};
                              state_in = S_MOD;
                           end
                        end
                        OP_COMMIT: begin
                           if (r_bad) begin
                              res_in.status = ST_INCONS;
                           end else if (!r_none) begin
                              res_in.status = (r[SLOT_AW-1:0] == req_ff.slot_in) ?
                                              ST_OK : ST_ALREADY;
                           end else if (owner_ff[req_ff.slot_in] == 64'd0) begin
                              state_in = S_COMMIT;
                           end else begin
                              key_in   = owner_ff[req_ff.slot_in];
                              step_in  = STEP_OLD;
                              idx_in   = '0;
                              state_in = S_RD;
                           end
                        end
                        OP_FREE: begin
                           if (r_bad) begin
                              res_in.status = ST_INCONS;
                           end else begin
                              if (!r_none) begin
                                 owner_in[r[SLOT_AW-1:0]]  = 64'd0;
                                 res_in.slot_out           = r[SLOT_AW-1:0];
                                 res_in.slot_clear_request = 1'b1;
                              end
                              valid_in[idx_ff] = 1'b0;
                              resid_in[idx_ff] = NOT_RES;
                              active_in        = active_ff - 6'd1;
                           end
                        end
                        default: begin
                           res_in.status = ST_INVALID;
                        end
                     endcase
                  end
               end
               STEP_OLD: begin
                  if (!hit_ff || r != {1'b0, req_ff.slot_in}) begin
                     res_in.status = ST_INCONS;
                  end else if (ent_ff.attr[3]) begin
                     res_in.status = ST_BUSY;
                  end else begin
                     resid_in[idx_ff] = NOT_RES;
                     state_in         = S_COMMIT;
                  end
               end
               STEP_VICTIM: begin
                  if (!hit_ff || r != c_ff) begin
                     res_in.status = ST_INCONS;
                  end else if (!ent_ff.attr[3]) begin
                     res_in.slot_out      = c_ff[SLOT_AW-1:0];
                     res_in.victim_handle = key_ff;
                  end else if (cnt_last) begin
                     res_in.status = ST_NOSPACE;
                  end else begin
                     c_in     = c_next;
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = S_SLOT;
                  end
               end
               default: begin
                  res_in.status = ST_INVALID;
               end
            endcase
         end
         S_MOD: begin
            if (c_ff >= siu_ff) begin
               c_in = c_ff - siu_ff;
            end else begin
               cstart_in = c_ff;
               cnt_in    = '0;
               pass2_in  = 1'b0;
               state_in  = S_SLOT;
            end
         end
         S_SLOT: begin
            if (pass2_ff) begin
               key_in   = owner_ff[c_ff[SLOT_AW-1:0]];
               step_in  = STEP_VICTIM;
               mode_in  = MODE_LOOKUP;
               idx_in   = '0;
               state_in = S_RD;
            end else if (owner_ff[c_ff[SLOT_AW-1:0]] == 64'd0) begin
               res_in.slot_out = c_ff[SLOT_AW-1:0];
               state_in        = S_OUT;
            end else if (cnt_last) begin
               pass2_in = 1'b1;
               cnt_in   = '0;
               c_in     = cstart_ff;
            end else begin
               c_in   = c_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            owner_in[req_ff.slot_in] = req_ff.handle_in;
            resid_in[e_ff]           = {1'b0, req_ff.slot_in};
            vp_in    = ({1'b0, req_ff.slot_in} + 5'd1 == siu_ff) ? '0 :
                       req_ff.slot_in + 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         siu_ff       <= SIU_RESET;
         last_ff      <= '0;
         active_ff    <= '0;
         vp_ff        <= '0;
         valid_ff     <= '{default: 1'b0};
         resid_ff     <= '{default: NOT_RES};
         owner_ff     <= '{default: 64'd0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         siu_ff       <= siu_in;
         last_ff      <= last_in;
         active_ff    <= active_in;
         vp_ff        <= vp_in;
         valid_ff     <= valid_in;
         resid_ff     <= resid_in;
         owner_ff     <= owner_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      key_ff      <= key_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      e_ff        <= e_in;
      fr_ff       <= fr_in;
      fr_found_ff <= fr_found_in;
      mode_ff     <= mode_in;
      step_ff     <= step_in;
      hit_ff      <= hit_in;
      ent_ff      <= ent_in;
      c_ff        <= c_in;
      cstart_ff   <= cstart_in;
      cnt_ff      <= cnt_in;
      pass2_ff    <= pass2_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTHESIS
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= 6'(ENTRIES))
      else $error("active count above table size");

   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.slot_clear_request |-> rsp_ff.status == ST_OK)
      else $error("slot clear on a failed transaction");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |->
         rsp_ff.handle_out == 64'd0 && rsp_ff.victim_handle == 64'd0)
      else $error("nonzero payload on error");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
`endif
endmodule
